// File: rtl/life_grid_aging_step_assert.svh
// assertion macros used by the grid memory and sequencer (lga_back) of the life grid rtl
`ifndef LIFE_GRID_AGING_STEP_ASSERT_SVH
`define LIFE_GRID_AGING_STEP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LGA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("life grid check failed");

// next-cycle implication, disabled during reset
`define LGA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("life grid check failed");

`endif

// File: rtl/lga_pkg.sv
// shared types and constants of the life grid block
`timescale 1ns / 1ps
`default_nettype none
package lga_pkg;

    // request type codes on the input tuser
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_STEP  = 2'd2;

    // result kind codes on the output tuser
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    // register indexes
    localparam logic [1:0] REG_WIDTH     = 2'd0;
    localparam logic [1:0] REG_HEIGHT    = 2'd1;
    localparam logic [1:0] REG_THRESHOLD = 2'd2;
    localparam logic [1:0] REG_AGE_STEP  = 2'd3;

    localparam logic [6:0] RST_WIDTH     = 7'd64;
    localparam logic [6:0] RST_HEIGHT    = 7'd64;
    localparam logic [7:0] RST_THRESHOLD = 8'd63;
    localparam logic [7:0] RST_AGE_STEP  = 8'd26;

    // classified operation carried through the queue
    typedef enum logic [1:0] {
        OP_WR,
        OP_RD,
        OP_RDZ,
        OP_STEP
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [5:0] x;
        logic [5:0] y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_req;

endpackage
`default_nettype wire

// File: rtl/lga_front.sv
// request classifier and two-entry queue of the life grid
`timescale 1ns / 1ps
`default_nettype none
module lga_front #(
    parameter int DIM_BITS = 7
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire [DIM_BITS-1:0]  i_dim_w,
    input  wire [DIM_BITS-1:0]  i_dim_h,
    input  wire                 i_clearing,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire [1:0]           i_req_type,
    input  wire [5:0]           i_x,
    input  wire [5:0]           i_y,
    input  wire [7:0]           i_red,
    input  wire [7:0]           i_green,
    input  wire [7:0]           i_blue,
    output logic                o_q_valid,
    output lga_pkg::t_req       o_q_req,
    input  wire                 i_q_pop
);
    import lga_pkg::*;

    t_req       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       in_area;
    logic       keep;
    logic       push;
    t_req       cls;

    assign in_area = (11'(i_x) < 11'(i_dim_w)) && (11'(i_y) < 11'(i_dim_h));

    always_comb begin
        cls.x     = i_x;
        cls.y     = i_y;
        cls.red   = i_red;
        cls.green = i_green;
        cls.blue  = i_blue;
        cls.op    = OP_WR;
        keep      = 1'b0;
        case (i_req_type)
            REQ_WRITE: begin
                cls.op = OP_WR;
                keep   = in_area;
            end
            REQ_READ: begin
                cls.op = in_area ? OP_RD : OP_RDZ;
                keep   = 1'b1;
            end
            REQ_STEP: begin
                cls.op = OP_STEP;
                keep   = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    assign o_ready   = !i_clearing && (r_cnt != 2'd2);
    assign push      = i_valid && o_ready && keep;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_req   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wp] <= cls;
                r_wp      <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

endmodule
`default_nettype wire

// File: rtl/lga_back.sv
// grid memory, generation sequencer and result register of the life grid
`timescale 1ns / 1ps
`default_nettype none
module lga_back #(
    parameter int MAX_WIDTH    = 64,
    parameter int MAX_HEIGHT   = 64,
    parameter int CHANNEL_BITS = 8,
    parameter int DIM_BITS     = 7
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire [DIM_BITS-1:0]  i_dim_w,
    input  wire [DIM_BITS-1:0]  i_dim_h,
    input  wire [7:0]           i_thr,
    input  wire [7:0]           i_age_step,
    input  wire                 i_q_valid,
    input  lga_pkg::t_req       i_q_req,
    output logic                o_q_pop,
    output logic                o_clearing,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output logic                o_out_kind,
    output logic [7:0]          o_out_red,
    output logic [7:0]          o_out_green,
    output logic [7:0]          o_out_blue
);
    import lga_pkg::*;

    `include "life_grid_aging_step_assert.svh"

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int OW    = $clog2(CELLS);
    localparam int AW    = OW + 1;
    localparam int CB    = CHANNEL_BITS;
    localparam int MW    = 3 * CB;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_RD_WAIT, S_CELL, S_READ, S_WAIT, S_CALC, S_DONE
    } t_state;

    logic [MW-1:0] mem [2**AW];

    t_state        r_state;
    logic [AW-1:0] r_clr;
    logic          r_bank;
    logic [XW-1:0] r_x;
    logic [YW-1:0] r_y;
    logic [1:0]    r_ci;
    logic [1:0]    r_rj;
    logic          r_cap_valid;
    logic [1:0]    r_cap_ci;
    logic [1:0]    r_cap_rj;
    logic [MW-1:0] r_win [3][3];
    logic [MW-1:0] r_rdata;
    logic          r_out_valid;
    logic          r_out_kind;
    logic [7:0]    r_out_red;
    logic [7:0]    r_out_green;
    logic [7:0]    r_out_blue;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          w_en;
    logic [AW-1:0] w_addr;
    logic [MW-1:0] w_data;
    logic          out_free;
    logic [XW-1:0] req_x;
    logic [YW-1:0] req_y;
    logic          in_area;
    logic [XW-1:0] xm1, xp1, col;
    logic [YW-1:0] ym1, yp1, row;
    logic          last_x, last_y;
    logic [3:0]    ncount;
    logic [CB-1:0] c_r, c_g, c_b;
    logic [CB-1:0] a_r, a_g, a_b;
    logic          live_c;
    logic [MW-1:0] next_color;

    function automatic logic [AW-1:0] cell_addr(input logic bank, input logic [XW-1:0] cx,
                                                input logic [YW-1:0] cy);
        cell_addr = {bank, OW'(cy * MAX_WIDTH + cx)};
    endfunction

    function automatic logic [CB-1:0] sat_sub(input logic [CB-1:0] c, input logic [7:0] s);
        sat_sub = (32'(c) > 32'(s)) ? CB'(32'(c) - 32'(s)) : '0;
    endfunction

    assign out_free = !r_out_valid || i_out_ready;
    assign req_x    = XW'(i_q_req.x);
    assign req_y    = YW'(i_q_req.y);
    assign in_area  = (DIM_BITS'(r_x) < i_dim_w) && (DIM_BITS'(r_y) < i_dim_h);
    assign last_x   = (r_x == XW'(MAX_WIDTH - 1));
    assign last_y   = (r_y == YW'(MAX_HEIGHT - 1));

    // torus neighbors of the current cell
    assign xm1 = (r_x == '0) ? XW'(i_dim_w - 1'b1) : r_x - 1'b1;
    assign xp1 = ((DIM_BITS'(r_x) + 1'b1) == i_dim_w) ? '0 : r_x + 1'b1;
    assign ym1 = (r_y == '0) ? YW'(i_dim_h - 1'b1) : r_y - 1'b1;
    assign yp1 = ((DIM_BITS'(r_y) + 1'b1) == i_dim_h) ? '0 : r_y + 1'b1;

    always_comb begin
        case (r_ci)
            2'd0:    col = xm1;
            2'd1:    col = r_x;
            default: col = xp1;
        endcase
        case (r_rj)
            2'd0:    row = ym1;
            2'd1:    row = r_y;
            default: row = yp1;
        endcase
    end

    // next color of the window center
    always_comb begin
        c_r    = r_win[1][1][CB-1:0];
        c_g    = r_win[1][1][2*CB-1:CB];
        c_b    = r_win[1][1][3*CB-1:2*CB];
        live_c = (c_r != '0);
        ncount = '0;
        for (int j = 0; j < 3; j++) begin
            for (int i = 0; i < 3; i++) begin
                if (!(i == 1 && j == 1)) begin
                    ncount = ncount + 4'(r_win[j][i][CB-1:0] != '0);
                end
            end
        end
        a_r = c_r;
        a_g = c_g;
        a_b = c_b;
        if (32'(c_r) > 32'(i_thr)) begin
            a_r = sat_sub(c_r, i_age_step);
        end else if (32'(c_g) > 32'(i_thr)) begin
            a_g = sat_sub(c_g, i_age_step);
        end else if (32'(c_b) > 32'(i_thr)) begin
            a_b = sat_sub(c_b, i_age_step);
        end
        if (live_c && (ncount == 4'd2 || ncount == 4'd3)) begin
            next_color = {a_b, a_g, a_r};
        end else if (!live_c && ncount == 4'd3) begin
            next_color = '1;
        end else begin
            next_color = '0;
        end
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = cell_addr(r_bank, col, row);
        w_en    = 1'b0;
        w_addr  = cell_addr(~r_bank, r_x, r_y);
        w_data  = '0;
        o_q_pop = 1'b0;
        case (r_state)
            S_CLEAR: begin
                w_en   = 1'b1;
                w_addr = r_clr;
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_req.op)
                        OP_WR: begin
                            o_q_pop = 1'b1;
                            w_en    = 1'b1;
                            w_addr  = cell_addr(r_bank, req_x, req_y);
                            w_data  = {CB'(i_q_req.blue), CB'(i_q_req.green), CB'(i_q_req.red)};
                        end
                        OP_RD: begin
                            o_q_pop = out_free;
                            rd_en   = out_free;
                            rd_addr = cell_addr(r_bank, req_x, req_y);
                        end
                        OP_RDZ:  o_q_pop = out_free;
                        default: o_q_pop = 1'b1;
                    endcase
                end
            end
            S_CELL:  w_en = !in_area;
            S_READ:  rd_en = 1'b1;
            S_CALC: begin
                w_en   = 1'b1;
                w_data = next_color;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_bank      <= 1'b0;
            r_cap_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cap_valid <= 1'b0;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_cap_valid) begin
                r_win[r_cap_rj][r_cap_ci] <= r_rdata;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (&r_clr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        case (i_q_req.op)
                            OP_RD: begin
                                if (out_free) begin
                                    r_state <= S_RD_WAIT;
                                end
                            end
                            OP_RDZ: begin
                                if (out_free) begin
                                    r_out_valid <= 1'b1;
                                    r_out_kind  <= KIND_READ;
                                    r_out_red   <= '0;
                                    r_out_green <= '0;
                                    r_out_blue  <= '0;
                                end
                            end
                            OP_STEP: begin
                                r_x     <= '0;
                                r_y     <= '0;
                                r_state <= S_CELL;
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD_WAIT: begin
                    r_out_valid <= 1'b1;
                    r_out_kind  <= KIND_READ;
                    r_out_red   <= 8'(r_rdata[CB-1:0]);
                    r_out_green <= 8'(r_rdata[2*CB-1:CB]);
                    r_out_blue  <= 8'(r_rdata[3*CB-1:2*CB]);
                    r_state     <= S_IDLE;
                end
                S_CELL: begin
                    r_rj <= 2'd0;
                    if (!in_area) begin
                        if (last_x) begin
                            r_x     <= '0;
                            r_y     <= r_y + 1'b1;
                            r_state <= last_y ? S_DONE : S_CELL;
                        end else begin
                            r_x <= r_x + 1'b1;
                        end
                    end else if (r_x == '0) begin
                        r_ci    <= 2'd0;
                        r_state <= S_READ;
                    end else begin
                        for (int j = 0; j < 3; j++) begin
                            r_win[j][0] <= r_win[j][1];
                            r_win[j][1] <= r_win[j][2];
                        end
                        r_ci    <= 2'd2;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_cap_valid <= 1'b1;
                    r_cap_ci    <= r_ci;
                    r_cap_rj    <= r_rj;
                    if (r_rj == 2'd2) begin
                        r_rj <= 2'd0;
                        if (r_ci == 2'd2) begin
                            r_state <= S_WAIT;
                        end else begin
                            r_ci <= r_ci + 1'b1;
                        end
                    end else begin
                        r_rj <= r_rj + 1'b1;
                    end
                end
                S_WAIT:  r_state <= S_CALC;
                S_CALC: begin
                    if (last_x) begin
                        r_x     <= '0;
                        r_y     <= r_y + 1'b1;
                        r_state <= last_y ? S_DONE : S_CELL;
                    end else begin
                        r_x     <= r_x + 1'b1;
                        r_state <= S_CELL;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_bank      <= ~r_bank;
                        r_out_valid <= 1'b1;
                        r_out_kind  <= KIND_STEP;
                        r_out_red   <= '0;
                        r_out_green <= '0;
                        r_out_blue  <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_clearing  = (r_state == S_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_red   = r_out_red;
    assign o_out_green = r_out_green;
    assign o_out_blue  = r_out_blue;

    `LGA_ASSERT_NOW(a_no_pop_in_clear, i_clk, i_rst_n, r_state == S_CLEAR, !o_q_pop)
    `LGA_ASSERT_NOW(a_no_write_in_read, i_clk, i_rst_n, r_state == S_READ, !w_en)
    `LGA_ASSERT_NEXT(a_bank_flip, i_clk, i_rst_n, r_state == S_DONE && out_free,
                     r_bank != $past(r_bank) && r_out_valid && r_out_kind == KIND_STEP)

endmodule
`default_nettype wire

// File: rtl/life_grid_aging_step.sv
// top level of the toroidal life grid with color aging
`timescale 1ns / 1ps
`default_nettype none
// Toroidal life grid with color aging. Cells hold red, green and blue channels in
// two banks of one grid memory; a write request (tuser 0) loads a cell of the
// current bank, a read request (tuser 1) returns its color, and a step request
// (tuser 2) computes one generation into the other bank, swaps banks and returns
// one transaction with tuser 1 and zero color. tuser 3 and writes outside the
// active area are dropped; reads outside it return zero. A step sweeps every cell
// slot of the grid: the first active cell of a row needs nine reads of the single
// grid memory read port and every other active cell three, each plus a visit, a
// wait and a write state. After reset a clearing pass zeroes the whole memory of
// 2^(clog2(MAX_WIDTH*MAX_HEIGHT)+1) entries (8192 by default), one entry a cycle,
// while s_axis_tready stays low; register writes are taken during it. A two-entry
// queue parts the request classifier from the sequencer, and a result register
// holds the outgoing transaction. Registers must only be written while the block
// idles.
module life_grid_aging_step #(
    parameter int MAX_WIDTH    = 64,
    parameter int MAX_HEIGHT   = 64,
    parameter int CHANNEL_BITS = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // request stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [39:0] s_axis_tdata,   // x[5:0], y[11:6], red[19:12], green[27:20], blue[35:28]
    input  wire  [1:0]  s_axis_tuser,   // req_type[1:0]
    // result stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic        m_axis_tuser,   // resp_kind[0]
    // register port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lga_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int DW = ((XW > YW) ? XW : YW) + 1;

    logic [6:0]    r_grid_w;
    logic [6:0]    r_grid_h;
    logic [7:0]    r_thr;
    logic [7:0]    r_age_step;
    logic [DW-1:0] dim_w;
    logic [DW-1:0] dim_h;
    logic          clearing;
    logic          q_valid;
    t_req          q_req;
    logic          q_pop;

    // register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w   <= RST_WIDTH;
            r_grid_h   <= RST_HEIGHT;
            r_thr      <= RST_THRESHOLD;
            r_age_step <= RST_AGE_STEP;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_WIDTH:     r_grid_w   <= pwdata[6:0];
                REG_HEIGHT:    r_grid_h   <= pwdata[6:0];
                REG_THRESHOLD: r_thr      <= pwdata[7:0];
                REG_AGE_STEP:  r_age_step <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_WIDTH:     prdata = 32'(r_grid_w);
            REG_HEIGHT:    prdata = 32'(r_grid_h);
            REG_THRESHOLD: prdata = 32'(r_thr);
            REG_AGE_STEP:  prdata = 32'(r_age_step);
            default:       prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // active size clamped to 3 .. MAX
    always_comb begin
        if (r_grid_w < 7'd3) begin
            dim_w = DW'(3);
        end else if (11'(r_grid_w) > 11'(MAX_WIDTH)) begin
            dim_w = DW'(MAX_WIDTH);
        end else begin
            dim_w = DW'(r_grid_w);
        end
        if (r_grid_h < 7'd3) begin
            dim_h = DW'(3);
        end else if (11'(r_grid_h) > 11'(MAX_HEIGHT)) begin
            dim_h = DW'(MAX_HEIGHT);
        end else begin
            dim_h = DW'(r_grid_h);
        end
    end

    lga_front #(
        .DIM_BITS (DW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dim_w    (dim_w),
        .i_dim_h    (dim_h),
        .i_clearing (clearing),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_req_type (s_axis_tuser),
        .i_x        (s_axis_tdata[5:0]),
        .i_y        (s_axis_tdata[11:6]),
        .i_red      (s_axis_tdata[19:12]),
        .i_green    (s_axis_tdata[27:20]),
        .i_blue     (s_axis_tdata[35:28]),
        .o_q_valid  (q_valid),
        .o_q_req    (q_req),
        .i_q_pop    (q_pop)
    );

    lga_back #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .CHANNEL_BITS (CHANNEL_BITS),
        .DIM_BITS     (DW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dim_w     (dim_w),
        .i_dim_h     (dim_h),
        .i_thr       (r_thr),
        .i_age_step  (r_age_step),
        .i_q_valid   (q_valid),
        .i_q_req     (q_req),
        .o_q_pop     (q_pop),
        .o_clearing  (clearing),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_kind  (m_axis_tuser),
        .o_out_red   (m_axis_tdata[7:0]),
        .o_out_green (m_axis_tdata[15:8]),
        .o_out_blue  (m_axis_tdata[23:16])
    );

endmodule
`default_nettype wire

// File: verif/tb.sv
// self-checking testbench for the toroidal life grid with color aging
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import lga_pkg::*;

    // request type left unused by the block, must be dropped
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    // cycles with no transaction on either stream before the run is abandoned;
    // covers the clearing pass and a full 64 by 64 generation under stall
    localparam int WATCHDOG_LIMIT = 200000;
    // settle time after the last result, more than a write needs to land
    localparam int SETTLE_CYCLES = 32;

    // expected result of one request
    typedef struct {
        logic        kind;
        logic [23:0] color;
    } t_result;

    // predicts the grid and holds the results still owed by the block
    class life_scoreboard;
        logic [23:0] cells [2][4096];   // {blue, green, red} per cell
        bit          bank;
        int unsigned width_reg, height_reg, threshold_reg, age_step_reg;
        t_result     owed [$];
        int          errors;

        function new();
            for (int k = 0; k < 4096; k++) begin
                cells[0][k] = '0;
                cells[1][k] = '0;
            end
            bank          = 0;
            width_reg     = RST_WIDTH;
            height_reg    = RST_HEIGHT;
            threshold_reg = RST_THRESHOLD;
            age_step_reg  = RST_AGE_STEP;
            errors        = 0;
        endfunction

        function int unsigned clamp_size(int unsigned v);
            if (v < 3) return 3;
            if (v > 64) return 64;
            return v;
        endfunction

        function void set_reg(logic [1:0] idx, int unsigned v);
            case (idx)
                REG_WIDTH:     width_reg     = v & 8'h7f;
                REG_HEIGHT:    height_reg    = v & 8'h7f;
                REG_THRESHOLD: threshold_reg = v & 8'hff;
                REG_AGE_STEP:  age_step_reg  = v & 8'hff;
                default: ;
            endcase
        endfunction

        function void next_generation();
            int unsigned w, h, n;
            int unsigned xs [3];
            int unsigned ys [3];
            bit          nxt, done;
            logic [23:0] c, o;
            logic [7:0]  ch [3];
            w   = clamp_size(width_reg);
            h   = clamp_size(height_reg);
            nxt = !bank;
            for (int k = 0; k < 4096; k++) cells[nxt][k] = '0;
            for (int y = 0; y < h; y++) begin
                for (int x = 0; x < w; x++) begin
                    xs[0] = (x == 0) ? w - 1 : x - 1;
                    xs[1] = x;
                    xs[2] = (x + 1 == w) ? 0 : x + 1;
                    ys[0] = (y == 0) ? h - 1 : y - 1;
                    ys[1] = y;
                    ys[2] = (y + 1 == h) ? 0 : y + 1;
                    n = 0;
                    for (int j = 0; j < 3; j++)
                        for (int i = 0; i < 3; i++)
                            if (!(i == 1 && j == 1) && cells[bank][ys[j] * 64 + xs[i]][7:0] != 0)
                                n++;
                    c = cells[bank][y * 64 + x];
                    o = '0;
                    if (c[7:0] != 0) begin
                        if (n == 2 || n == 3) begin
                            // only the first channel above the threshold ages
                            ch[0] = c[7:0];
                            ch[1] = c[15:8];
                            ch[2] = c[23:16];
                            done  = 0;
                            for (int k = 0; k < 3; k++) begin
                                if (!done && ch[k] > threshold_reg) begin
                                    done  = 1;
                                    ch[k] = (ch[k] > age_step_reg) ?
                                            8'(ch[k] - age_step_reg) : 8'd0;
                                end
                            end
                            o = {ch[2], ch[1], ch[0]};
                        end
                    end else if (n == 3) begin
                        o = 24'hffffff;
                    end
                    cells[nxt][y * 64 + x] = o;
                end
            end
            bank = nxt;
        endfunction

        // accepted request transaction
        function void note_request(logic [1:0] req, logic [39:0] data);
            logic [5:0] x, y;
            bit         in_area;
            t_result    r;
            x       = data[5:0];
            y       = data[11:6];
            in_area = (x < clamp_size(width_reg)) && (y < clamp_size(height_reg));
            case (req)
                REQ_WRITE: if (in_area) cells[bank][y * 64 + x] = data[35:12];
                REQ_READ: begin
                    r.kind  = KIND_READ;
                    r.color = in_area ? cells[bank][y * 64 + x] : 24'd0;
                    owed.push_back(r);
                end
                REQ_STEP: begin
                    next_generation();
                    r.kind  = KIND_STEP;
                    r.color = '0;
                    owed.push_back(r);
                end
                default: ;
            endcase
        endfunction

        task report(string what, int unsigned got, int unsigned want);
            $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        // accepted result transaction
        task check_result(logic kind, logic [23:0] color);
            t_result r;
            if (owed.size() == 0) begin
                report("unexpected result", {kind, color}, 0);
            end else begin
                r = owed.pop_front();
                if (kind !== r.kind)               report("kind", kind, r.kind);
                if (color[7:0] !== r.color[7:0])   report("red", color[7:0], r.color[7:0]);
                if (color[15:8] !== r.color[15:8]) report("green", color[15:8], r.color[15:8]);
                if (color[23:16] !== r.color[23:16])
                    report("blue", color[23:16], r.color[23:16]);
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // x[5:0], y[11:6], red[19:12], green[27:20], blue[35:28]
    logic [1:0]  s_axis_tuser = '0;   // req_type[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;        // red[7:0], green[15:8], blue[23:16]
    logic        m_axis_tuser;        // resp_kind[0]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    life_scoreboard grid_sb = new();
    int unsigned    send_idle_pct = 0;
    int unsigned    recv_stall_pct = 0;
    int unsigned    quiet_cycles = 0;

    life_grid_aging_step DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    // receiver backpressure, redrawn every cycle
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // monitor both streams and the watchdog on the pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            grid_sb.note_request(s_axis_tuser, s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            grid_sb.check_result(m_axis_tuser, m_axis_tdata);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // one register write: setup then access cycle
    task reg_write(logic [1:0] idx, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        grid_sb.set_reg(idx, v);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // hold valid until the block takes the request transaction
    task send_req(logic [1:0] req, logic [5:0] x, logic [5:0] y,
                  logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {4'd0, b, g, r, y, x};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // drain all owed results, then let trailing writes settle
    task wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (grid_sb.owed.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task configure(int unsigned w, int unsigned h, int unsigned th, int unsigned st,
                   int unsigned idle, int unsigned stall);
        wait_idle();
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
        reg_write(REG_THRESHOLD, th);
        reg_write(REG_AGE_STEP, st);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
    endtask

    function automatic logic [7:0] pick_channel();
        case ($urandom_range(3))
            0: return 8'd0;
            1: return 8'hff;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // mostly dense writes in the active area with reads, a few generations and some unused requests
    task random_phase(int n);
        int unsigned w, h, sel;
        logic [5:0]  x, y;
        logic [7:0]  r;
        w = grid_sb.clamp_size(grid_sb.width_reg);
        h = grid_sb.clamp_size(grid_sb.height_reg);
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(99);
            if ($urandom_range(99) < 85) begin
                x = 6'($urandom_range(w - 1));
                y = 6'($urandom_range(h - 1));
            end else begin
                x = 6'($urandom_range(63));
                y = 6'($urandom_range(63));
            end
            r = ($urandom_range(1) != 0) ? pick_channel() : 8'd0;
            if (sel < 55)      send_req(REQ_WRITE, x, y, r, pick_channel(), pick_channel());
            else if (sel < 85) send_req(REQ_READ, x, y, 8'($urandom), 8'($urandom), 8'($urandom));
            else if (sel < 95) send_req(REQ_STEP, x, y, 8'($urandom), 8'($urandom), 8'($urandom));
            else send_req(REQ_UNUSED, x, y, 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full size grid: corner cells and one wide generation
        configure(64, 64, 63, 26, 0, 0);
        send_req(REQ_WRITE, 6'd63, 6'd63, 8'hff, 8'hff, 8'hff);
        send_req(REQ_WRITE, 6'd0, 6'd0, 8'h80, 8'h00, 8'h7f);
        send_req(REQ_READ, 6'd63, 6'd63, 8'h00, 8'h00, 8'h00);
        send_req(REQ_UNUSED, 6'd0, 6'd0, 8'h00, 8'h00, 8'h00);
        send_req(REQ_STEP, 6'd0, 6'd0, 8'h00, 8'h00, 8'h00);
        send_req(REQ_READ, 6'd0, 6'd0, 8'h00, 8'h00, 8'h00);

        // blinker in a 5 by 5 grid with underflowing age step
        configure(5, 5, 0, 255, 0, 0);
        send_req(REQ_WRITE, 6'd1, 6'd2, 8'd200, 8'd100, 8'd50);
        send_req(REQ_WRITE, 6'd2, 6'd2, 8'd10, 8'd255, 8'd1);
        send_req(REQ_WRITE, 6'd3, 6'd2, 8'hff, 8'hff, 8'hff);
        // outside the active area: dropped, and reads back zero
        send_req(REQ_WRITE, 6'd40, 6'd2, 8'hff, 8'hff, 8'hff);
        send_req(REQ_READ, 6'd40, 6'd2, 8'h00, 8'h00, 8'h00);
        send_req(REQ_UNUSED, 6'd2, 6'd2, 8'h00, 8'h00, 8'h00);
        send_req(REQ_STEP, 6'd0, 6'd0, 8'h00, 8'h00, 8'h00);
        send_req(REQ_READ, 6'd2, 6'd1, 8'h00, 8'h00, 8'h00);
        send_req(REQ_READ, 6'd2, 6'd2, 8'h00, 8'h00, 8'h00);
        send_req(REQ_READ, 6'd2, 6'd3, 8'h00, 8'h00, 8'h00);
        send_req(REQ_STEP, 6'd0, 6'd0, 8'h00, 8'h00, 8'h00);
        send_req(REQ_READ, 6'd1, 6'd2, 8'h00, 8'h00, 8'h00);
        send_req(REQ_READ, 6'd3, 6'd2, 8'h00, 8'h00, 8'h00);

        // sizes below and above the clamp range, then ordinary settings
        configure(0, 2, 255, 0, 77, 0);
        random_phase(20);
        configure(127, 3, 100, 30, 0, 77);
        random_phase(20);
        configure(7, 9, 63, 26, 15, 15);
        random_phase(30);
        configure(12, 6, 128, 64, 0, 0);
        random_phase(30);
        configure(4, 4, 0, 1, 77, 77);
        random_phase(20);

        wait_idle();
        if (grid_sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
